/* rtl/capped_gated_activation_macros.svh */
// assertion macros used by the asserting top-level file
`ifndef CAPPED_GATED_ACTIVATION_MACROS_SVH
`define CAPPED_GATED_ACTIVATION_MACROS_SVH

// expression must hold at every clock edge out of reset
`define CGA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define CGA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, checked through reset
`define CGA_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/cga_pkg.sv */
// ----------------------------------------------------------------------------
// cga_pkg
// shared types, constants and the activation breakpoint tables
// ----------------------------------------------------------------------------
package cga_pkg;

   localparam int TABLE_SEGMENTS = 64;
   localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
   localparam int TANH_FRAC      = 26 - SEG_BITS;
   localparam int SIG_FRAC       = 15 - SEG_BITS;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

   localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
   localparam logic [63:0] Q30_MASK  = Q30_ONE - 64'd1;
   localparam logic [63:0] E_INV_Q30 = 64'd395007542;

   // register indexes
   localparam logic [2:0] REG_GATE_CAP       = 3'd0;
   localparam logic [2:0] REG_GATE_CAP_RECIP = 3'd1;
   localparam logic [2:0] REG_UP_CAP         = 3'd2;
   localparam logic [2:0] REG_UP_CAP_RECIP   = 3'd3;
   localparam logic [14:0] BETA_RESET        = 15'd4096;

   typedef logic [30:0] cga_table_type [0:TABLE_SEGMENTS];

   // one classified item between front and back
   typedef struct packed {
      logic [30:0] tanh_arg_one;
      logic [30:0] tanh_arg_two;
      logic [15:0] gate_mag;
      logic        gate_neg;
      logic        result_neg;
      logic        zero;
      logic        last;
   } cga_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cga_queue_status_type;

   // restoring long division for table construction, divisor below 2^63
   function automatic logic [63:0] long_div(input logic [63:0] num,
                                            input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-y with y and result in q30
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
      logic [63:0]        n;
      logic [63:0]        f;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] sum;
      n    = y >> 30;
      f    = y & Q30_MASK;
      term = Q30_ONE;
      sum  = $signed(Q30_ONE);
      for (int i = 1; i <= 14; i++) begin
         term = long_div((term * f) >> 30, 64'(i));
         if (i[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = $unsigned(sum);
      if (r > Q30_ONE) begin
         r = Q30_ONE;
      end
      for (int j = 0; j < 16; j++) begin
         if (64'(j) < n) begin
            r = (r * E_INV_Q30) >> 30;
         end
      end
      return r;
   endfunction

   // breakpoint values, tanh over [0,4] or sigmoid over [0,8]
   function automatic cga_table_type build_table(input logic use_tanh);
      cga_table_type tbl;
      logic [63:0]   e;
      logic [63:0]   v;
      for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
         e = exp_neg_q30(((64'd8 * 64'(k)) << 30) >> SEG_BITS);
         if (use_tanh) begin
            v = long_div((Q30_ONE - e) << 30, Q30_ONE + e);
         end else begin
            v = long_div(Q30_ONE << 30, Q30_ONE + e);
         end
         tbl[k] = v[30:0];
      end
      return tbl;
   endfunction

   localparam cga_table_type TANH_TABLE = build_table(1'b1);
   localparam cga_table_type SIG_TABLE  = build_table(1'b0);

endpackage

/* rtl/cga_queue.sv */
// ----------------------------------------------------------------------------
// cga_queue
// short fifo between the front and back parts
// ----------------------------------------------------------------------------
module cga_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  cga_pkg::cga_item_type         push_item,
   input  logic                          pop,
   output cga_pkg::cga_item_type         pop_item,
   output cga_pkg::cga_queue_status_type status
);
   import cga_pkg::*;

   cga_item_type           mem_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* rtl/cga_front.sv */
// ----------------------------------------------------------------------------
// cga_front
// accepts items, takes magnitudes and signs, forms the tanh arguments
// ----------------------------------------------------------------------------
module cga_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [15:0]    req_gate_value,
   input  logic signed [15:0]    req_up_value,
   input  logic                  req_last_in,
   input  logic [14:0]           gate_cap,
   input  logic [14:0]           gate_cap_recip,
   input  logic [14:0]           up_cap,
   input  logic [14:0]           up_cap_recip,
   input  logic                  queue_full,
   output logic                  push,
   output cga_pkg::cga_item_type push_item
);
   import cga_pkg::*;

   logic         take;
   logic         vld_ff, vld_in;
   cga_item_type item_ff, item_in;
   logic [15:0]  gate_mag;
   logic [15:0]  up_mag;

   assign req_stall = vld_ff & queue_full;
   assign take      = req_valid & ~req_stall;
   assign push      = vld_ff & ~queue_full;
   assign push_item = item_ff;

   // classify the incoming item
   always_comb begin
      gate_mag = req_gate_value[15] ? 16'(-req_gate_value) : req_gate_value;
      up_mag   = req_up_value[15] ? 16'(-req_up_value) : req_up_value;
      item_in.tanh_arg_one = 31'(gate_mag) * 31'(gate_cap_recip);
      item_in.tanh_arg_two = 31'(up_mag) * 31'(up_cap_recip);
      item_in.gate_mag     = gate_mag;
      item_in.gate_neg     = req_gate_value[15];
      item_in.result_neg   = req_gate_value[15] ^ req_up_value[15];
      item_in.zero         = (gate_cap == '0) | (up_cap == '0);
      item_in.last         = req_last_in;
      vld_in               = take | (vld_ff & ~push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/cga_back.sv */
// ----------------------------------------------------------------------------
// cga_back
// table lookup, interpolation and the product chain, one stage per multiply
// ----------------------------------------------------------------------------
module cga_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  cga_pkg::cga_item_type pop_item,
   output logic                  pop,
   input  logic [14:0]           gate_cap,
   input  logic [14:0]           up_cap,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_activated,
   output logic                  rsp_last_out
);
   import cga_pkg::*;

   localparam int STAGES = 7;

   logic                  en;
   logic [STAGES-1:0]     vld_ff;
   logic [STAGES-1:0]     vld_in;
   // sideband carried down the pipe
   logic [STAGES-1:0]     neg_ff, zero_ff, last_ff, gneg_ff;

   // stage a: lookup
   logic                  sat1_a_ff, sat2_a_ff, sats_a_ff;
   logic [30:0]           t1v0_ff, t1v1_ff, t2v0_ff, t2v1_ff, sv0_ff, sv1_ff;
   logic [TANH_FRAC-1:0]  fr1_ff, fr2_ff;
   logic [SIG_FRAC-1:0]   frs_ff;
   logic [SEG_BITS-1:0]   k1, k2, ks;
   // stage b: interpolated values
   logic [30:0]           t1_ff, t2_b_ff, sig_b_ff;
   logic [30:0]           t1_in, t2_in, sig_in;
   // stage c onward
   logic [30:0]           t2_c_ff, t2_d_ff, t2_e_ff;
   logic [30:0]           sig_c_ff;
   logic [21:0]           p1_ff;
   logic [22:0]           p2_ff;
   logic [23:0]           p3_ff;
   logic [24:0]           p4_ff;
   logic [31:0]           out_ff;

   assign en  = ~rsp_valid | ~rsp_stall;
   assign pop = en & ~queue_empty;

   // valid and sideband shift
   always_comb begin
      vld_in = {vld_ff[STAGES-2:0], ~queue_empty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= {neg_ff[STAGES-2:0], pop_item.result_neg};
         zero_ff <= {zero_ff[STAGES-2:0], pop_item.zero};
         last_ff <= {last_ff[STAGES-2:0], pop_item.last};
         gneg_ff <= {gneg_ff[STAGES-2:0], pop_item.gate_neg};
      end
   end

   // segment indexes
   always_comb begin
      k1 = pop_item.tanh_arg_one[25 -: SEG_BITS];
      k2 = pop_item.tanh_arg_two[25 -: SEG_BITS];
      ks = pop_item.gate_mag[14 -: SEG_BITS];
   end

   // stage a: saturation checks and breakpoint reads
   always_ff @(posedge clock) begin
      if (en) begin
         sat1_a_ff <= (pop_item.tanh_arg_one[30:26] != '0);
         sat2_a_ff <= (pop_item.tanh_arg_two[30:26] != '0);
         sats_a_ff <= pop_item.gate_mag[15];
         t1v0_ff   <= TANH_TABLE[k1];
         t1v1_ff   <= TANH_TABLE[(SEG_BITS+1)'(k1) + 1'b1];
         t2v0_ff   <= TANH_TABLE[k2];
         t2v1_ff   <= TANH_TABLE[(SEG_BITS+1)'(k2) + 1'b1];
         sv0_ff    <= SIG_TABLE[ks];
         sv1_ff    <= SIG_TABLE[(SEG_BITS+1)'(ks) + 1'b1];
         fr1_ff    <= pop_item.tanh_arg_one[TANH_FRAC-1:0];
         fr2_ff    <= pop_item.tanh_arg_two[TANH_FRAC-1:0];
         frs_ff    <= pop_item.gate_mag[SIG_FRAC-1:0];
      end
   end

   // stage b: linear interpolation, v0 + (v1 - v0) * frac, full-width product, 1.0 on saturation
   always_comb begin
      t1_in  = sat1_a_ff ? Q30_ONE[30:0] :
               t1v0_ff + 31'(((31+TANH_FRAC)'(t1v1_ff - t1v0_ff) *
                              (31+TANH_FRAC)'(fr1_ff)) >> TANH_FRAC);
      t2_in  = sat2_a_ff ? Q30_ONE[30:0] :
               t2v0_ff + 31'(((31+TANH_FRAC)'(t2v1_ff - t2v0_ff) *
                              (31+TANH_FRAC)'(fr2_ff)) >> TANH_FRAC);
      sig_in = sats_a_ff ? Q30_ONE[30:0] :
               sv0_ff + 31'(((31+SIG_FRAC)'(sv1_ff - sv0_ff) *
                             (31+SIG_FRAC)'(frs_ff)) >> SIG_FRAC);
   end

   // stages c to g: product chain and sign
   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff    <= t1_in;
         t2_b_ff  <= t2_in;
         sig_b_ff <= sig_in;
         p1_ff    <= 22'((46'(gate_cap) * 46'(t1_ff)) >> 24);
         sig_c_ff <= gneg_ff[1] ? Q30_ONE[30:0] - sig_b_ff : sig_b_ff;
         t2_c_ff  <= t2_b_ff;
         p2_ff    <= 23'((53'(p1_ff) * 53'(sig_c_ff)) >> 30);
         t2_d_ff  <= t2_c_ff;
         p3_ff    <= 24'((38'(p2_ff) * 38'(up_cap)) >> 14);
         t2_e_ff  <= t2_d_ff;
         p4_ff    <= 25'((55'(p3_ff) * 55'(t2_e_ff)) >> 30);
         if (zero_ff[5]) begin
            out_ff <= '0;
         end else if (neg_ff[5]) begin
            out_ff <= 32'(-{7'd0, p4_ff});
         end else begin
            out_ff <= {7'd0, p4_ff};
         end
      end
   end

   assign rsp_valid     = vld_ff[STAGES-1];
   assign rsp_activated = out_ff;
   assign rsp_last_out  = last_ff[STAGES-1];

endmodule

/* rtl/capped_gated_activation.sv */
// ----------------------------------------------------------------------------
// capped_gated_activation
// tanh-capped gated activation, b1*tanh(g/b1)*sigmoid(g)*b2*tanh(u/b2)
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries a signed q4.12 gate and up value and a last flag;
//   rsp_ channel returns the signed q16.16 result and the copied flag.
//   csr_ port writes beta one, its reciprocal, beta two and its reciprocal
//   (index 0 to 3, unsigned q3.12); writes to other indexes are dropped.
// throughput: one transfer per cycle on each channel, sustained while rsp_stall stays low.
// path: a request transfer passes through the front register and the
//   queue, then through the seven back stages (lookup, interpolation,
//   four multiplies, sign), the first of which loads on the pop.
// the back pipe moves as a whole and holds while the result is stalled;
//   the 4-entry queue absorbs the front meanwhile, and req_stall rises
//   only once it is full.
// reset clears all valid state and loads every configuration register with 1.0.
// ----------------------------------------------------------------------------
`include "capped_gated_activation_macros.svh"

module capped_gated_activation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_gate_value,
   input  logic signed [15:0] req_up_value,
   input  logic               req_last_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_activated,
   output logic               rsp_last_out,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_write_data
);
   import cga_pkg::*;

   logic [14:0]          gate_cap_ff, gate_cap_recip_ff;
   logic [14:0]          up_cap_ff, up_cap_recip_ff;
   logic                 push;
   logic                 pop;
   cga_item_type         push_item;
   cga_item_type         pop_item;
   cga_queue_status_type qstat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_cap_ff       <= BETA_RESET;
         gate_cap_recip_ff <= BETA_RESET;
         up_cap_ff         <= BETA_RESET;
         up_cap_recip_ff   <= BETA_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_GATE_CAP:       gate_cap_ff       <= csr_write_data;
            REG_GATE_CAP_RECIP: gate_cap_recip_ff <= csr_write_data;
            REG_UP_CAP:         up_cap_ff         <= csr_write_data;
            REG_UP_CAP_RECIP:   up_cap_recip_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   cga_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_gate_value (req_gate_value),
      .req_up_value   (req_up_value),
      .req_last_in    (req_last_in),
      .gate_cap       (gate_cap_ff),
      .gate_cap_recip (gate_cap_recip_ff),
      .up_cap         (up_cap_ff),
      .up_cap_recip   (up_cap_recip_ff),
      .queue_full     (qstat.full),
      .push           (push),
      .push_item      (push_item)
   );

   cga_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (qstat)
   );

   cga_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (qstat.empty),
      .pop_item      (pop_item),
      .pop           (pop),
      .gate_cap      (gate_cap_ff),
      .up_cap        (up_cap_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_activated (rsp_activated),
      .rsp_last_out  (rsp_last_out)
   );

   // checks
   `CGA_ASSERT_ALWAYS(a_queue_sane, clock, reset, !(qstat.full && qstat.empty))
   `CGA_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, qstat.full)
   `CGA_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, !qstat.empty)
   `CGA_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid && !req_stall)

endmodule
